// ===== sv/hfe_tbe_pkg.sv =====
// Package for the HFE track bit-cell extractor.
// Holds the shared widths, register indexes, v3 opcodes and the command type
// that the front end hands to the back end. Depends on nothing.
`default_nettype none

package hfe_tbe_pkg;

    // Default interleave geometry of an HFE track.
    localparam int DEFAULT_BLOCK_BYTES      = 512;
    localparam int DEFAULT_HALF_BLOCK_BYTES = 256;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int CELLS_PER_BYTE = 8;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_V3   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIDE_SELECT = 1'b1;

    // v3 opcodes, as seen after bit reversal.
    localparam logic [BYTE_W-1:0] OP_NOP     = 8'hF0;
    localparam logic [BYTE_W-1:0] OP_INDEX   = 8'hF1;
    localparam logic [BYTE_W-1:0] OP_BITRATE = 8'hF2;
    localparam logic [BYTE_W-1:0] OP_SKIP    = 8'hF3;
    localparam logic [BYTE_W-1:0] OP_RAND    = 8'hF4;

    // Command queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One unit of work for the back end. For a data command value is the raw
    // byte; for a run command value is the run length in cells (never zero).
    typedef struct packed {
        logic              is_run;
        logic              weak_run;
        logic [BYTE_W-1:0] value;
    } hfe_tbe_cmd_t;

endpackage

`default_nettype wire

// ===== sv/hfe_tbe_front.sv =====
// Front end of the HFE track bit-cell extractor: side selection, position
// counting, v3 opcode parsing and the configuration registers.
// Depends on hfe_tbe_pkg.
`default_nettype none

module hfe_tbe_front
    import hfe_tbe_pkg::*;
#(
    parameter int BLOCK_BYTES      = DEFAULT_BLOCK_BYTES,
    parameter int HALF_BLOCK_BYTES = DEFAULT_HALF_BLOCK_BYTES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic                  cfg_wdata,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [BYTE_W-1:0]     track_byte,
    input  wire logic                  track_end,
    output      logic                  cmd_push,
    output      hfe_tbe_cmd_t          cmd,
    input  wire logic                  queue_full
);

    localparam int POS_W = $clog2(BLOCK_BYTES);

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_RATE_TWO = 2'd1;
    localparam logic [1:0] MODE_RATE_ONE = 2'd2;
    localparam logic [1:0] MODE_COUNT    = 2'd3;

    logic             format_v3_reg;
    logic             side_select_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic             pending_weak_reg;
    logic             pending_weak_next;

    logic              accept;
    logic              kept;
    logic [31:0]       pos_wide;
    logic [BYTE_W-1:0] rev_byte;

    function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign pos_wide = 32'(pos_reg);
    assign kept     = side_select_reg ? (pos_wide >= 32'(HALF_BLOCK_BYTES))
                                      : (pos_wide <  32'(HALF_BLOCK_BYTES));
    assign rev_byte = reverse_byte(track_byte);

    always_comb
    begin
        mode_next         = mode_reg;
        pending_weak_next = pending_weak_reg;
        cmd_push          = 1'b0;
        cmd.is_run        = 1'b0;
        cmd.weak_run      = 1'b0;
        cmd.value         = track_byte;

        if (kept)
        begin
            if (!format_v3_reg)
            begin
                cmd_push = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    MODE_RATE_TWO:
                    begin
                        mode_next = MODE_RATE_ONE;
                    end
                    MODE_RATE_ONE:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    MODE_COUNT:
                    begin
                        mode_next         = MODE_IDLE;
                        pending_weak_next = 1'b0;
                        cmd.is_run        = 1'b1;
                        cmd.weak_run      = pending_weak_reg;
                        cmd.value         = rev_byte;
                        // A zero-length run yields nothing.
                        cmd_push          = (rev_byte != '0);
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        if (rev_byte == OP_NOP || rev_byte == OP_INDEX)
                        begin
                            cmd_push = 1'b0;
                        end
                        else if (rev_byte == OP_BITRATE)
                        begin
                            mode_next = MODE_RATE_TWO;
                        end
                        else if (rev_byte == OP_SKIP)
                        begin
                            mode_next         = MODE_COUNT;
                            pending_weak_next = 1'b0;
                        end
                        else if (rev_byte == OP_RAND)
                        begin
                            mode_next         = MODE_COUNT;
                            pending_weak_next = 1'b1;
                        end
                        else
                        begin
                            cmd_push = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (pos_reg == POS_W'(BLOCK_BYTES - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        // The end of a track restarts the block and drops any open opcode.
        if (track_end)
        begin
            pos_next          = '0;
            mode_next         = MODE_IDLE;
            pending_weak_next = 1'b0;
        end

        if (!accept)
        begin
            cmd_push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_v3_reg    <= 1'b1;
            side_select_reg  <= 1'b0;
            pos_reg          <= '0;
            mode_reg         <= MODE_IDLE;
            pending_weak_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == REG_FORMAT_V3)
            begin
                format_v3_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_SIDE_SELECT)
            begin
                side_select_reg <= cfg_wdata;
            end
            if (accept)
            begin
                pos_reg          <= pos_next;
                mode_reg         <= mode_next;
                pending_weak_reg <= pending_weak_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/hfe_tbe_queue.sv =====
// Small command queue between the front and back ends of the extractor.
// Depends on hfe_tbe_pkg.
`default_nettype none

module hfe_tbe_queue
    import hfe_tbe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire hfe_tbe_cmd_t push_cmd,
    output      logic         full,
    input  wire logic         pop,
    output      logic         pop_valid,
    output      hfe_tbe_cmd_t pop_cmd
);

    hfe_tbe_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hfe_tbe_back.sv =====
// Back end of the extractor: turns queued commands into groups of cells,
// splitting zero runs into chunks of up to eight, behind an output register.
// Depends on hfe_tbe_pkg.
`default_nettype none

module hfe_tbe_back
    import hfe_tbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire hfe_tbe_cmd_t       cmd,
    output      logic               cmd_pop,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [BYTE_W-1:0]  cell_bits,
    output      logic [COUNT_W-1:0] cell_count,
    output      logic               weak_cells,
    output      logic               run_last
);

    logic               valid_reg;
    logic               valid_next;
    logic [BYTE_W-1:0]  bits_reg;
    logic [BYTE_W-1:0]  bits_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               weak_reg;
    logic               weak_next;
    logic               last_reg;
    logic               last_next;
    logic [BYTE_W-1:0]  rem_reg;
    logic [BYTE_W-1:0]  rem_next;
    logic               run_weak_reg;
    logic               run_weak_next;

    logic               out_free;
    logic               run_start;
    logic [BYTE_W-1:0]  run_src;
    logic [COUNT_W-1:0] chunk;

    assign out_free  = !valid_reg || out_ready;
    assign run_start = (rem_reg == '0) && cmd_valid && cmd.is_run;
    assign run_src   = (rem_reg != '0) ? rem_reg : cmd.value;
    assign chunk     = (run_src > BYTE_W'(CELLS_PER_BYTE)) ? COUNT_W'(CELLS_PER_BYTE)
                                                           : run_src[COUNT_W-1:0];

    always_comb
    begin
        valid_next    = valid_reg;
        bits_next     = bits_reg;
        count_next    = count_reg;
        weak_next     = weak_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;
        run_weak_next = run_weak_reg;
        cmd_pop       = 1'b0;

        if (out_free)
        begin
            if (rem_reg != '0 || run_start)
            begin
                // Next chunk of a zero run, possibly its first.
                cmd_pop       = run_start;
                valid_next    = 1'b1;
                bits_next     = '0;
                count_next    = chunk;
                weak_next     = run_start ? cmd.weak_run : run_weak_reg;
                run_weak_next = weak_next;
                rem_next      = run_src - BYTE_W'(chunk);
                last_next     = (rem_next == '0);
            end
            else if (cmd_valid)
            begin
                cmd_pop    = 1'b1;
                valid_next = 1'b1;
                bits_next  = cmd.value;
                count_next = COUNT_W'(CELLS_PER_BYTE);
                weak_next  = 1'b0;
                last_next  = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        count_reg    <= count_next;
        weak_reg     <= weak_next;
        last_reg     <= last_next;
        run_weak_reg <= run_weak_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    assign out_valid  = valid_reg;
    assign cell_bits  = bits_reg;
    assign cell_count = count_reg;
    assign weak_cells = weak_reg;
    assign run_last   = last_reg;

    // A run still being split always has its previous chunk on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != '0 |-> valid_reg)
        else $error("run in progress without a pending output");

    // Every group carries between one and eight cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (count_reg != '0 && count_reg <= COUNT_W'(CELLS_PER_BYTE)))
        else $error("cell count out of range");

    // A group that is not the last of its byte must leave run cells behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !last_reg |-> rem_reg != '0)
        else $error("non-final group with no run remaining");

    // Weak cells only come from zero runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && weak_reg |-> bits_reg == '0)
        else $error("weak group carries data bits");

endmodule

`default_nettype wire

// ===== sv/hfe_track_bitcell_extractor.sv =====
// Top level of the HFE track bit-cell extractor.
// Instantiates the front end, the command queue and the back end.
// Depends on hfe_tbe_pkg, hfe_tbe_front, hfe_tbe_queue and hfe_tbe_back.
//
// Usage: the input stream carries the raw interleaved bytes of one HFE track,
// one byte per item, with tlast marking the final byte of the track. The
// output stream carries groups of bit cells: tdata holds the cells (earliest
// cell in bit 0) and the number of valid cells, tuser flags cells of a weak
// (random) run, and tlast marks the last group caused by one input byte.
// Bytes of the other disk side and v3 opcodes give no output at all.
//
// An accepted byte passes through the command queue and then the output
// register before its first group appears. Data bytes flow at one per cycle
// while the receiver takes every group; a zero run of L cells occupies the
// back end for ceil(L/8) groups. A four-entry command queue lets the front end
// keep accepting bytes meanwhile; the input stalls only when that queue is full.
//
// Reset clears the position counter, the opcode parser, the queue and the
// output register, and sets the format to v3 and the side to side 0. When the
// receiver stalls, the output register holds its group, the back end stops,
// and the queue fills up before tready drops. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata, by the user only while no item is in flight; the block does not enforce this.
`default_nettype none

module hfe_track_bitcell_extractor
    import hfe_tbe_pkg::*;
#(
    parameter int BLOCK_BYTES      = DEFAULT_BLOCK_BYTES,
    parameter int HALF_BLOCK_BYTES = DEFAULT_HALF_BLOCK_BYTES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration: index 0 is format_v3, index 1 is side_select.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic                  cfg_wdata,
    // Input stream.
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] track_byte
    input  wire logic                  s_axis_tlast,   // track_end
    // Output stream.
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [15:0]           m_axis_tdata,   // [7:0] cell_bits, [11:8] cell_count
    output      logic                  m_axis_tuser,   // weak_cells
    output      logic                  m_axis_tlast    // run_last
);

    logic               cmd_push;
    hfe_tbe_cmd_t       push_cmd;
    logic               queue_full;
    logic               cmd_pop;
    logic               cmd_valid;
    hfe_tbe_cmd_t       pop_cmd;
    logic [BYTE_W-1:0]  cell_bits;
    logic [COUNT_W-1:0] cell_count;

    hfe_tbe_front #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .HALF_BLOCK_BYTES (HALF_BLOCK_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .track_byte (s_axis_tdata),
        .track_end  (s_axis_tlast),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .queue_full (queue_full)
    );

    hfe_tbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .pop_cmd   (pop_cmd)
    );

    hfe_tbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cell_bits  (cell_bits),
        .cell_count (cell_count),
        .weak_cells (m_axis_tuser),
        .run_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, cell_count, cell_bits};

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for hfe_track_bitcell_extractor.
// Streams HFE track bytes in v1 and v3 format on both disk sides and checks
// every cell group against a predictor of its own. Depends on hfe_tbe_pkg and hfe_track_bitcell_extractor.
`default_nettype none

module tb;
    import hfe_tbe_pkg::*;

    // Interleave geometry of the instance (the block runs with its defaults).
    localparam int BLOCK_LEN = DEFAULT_BLOCK_BYTES;
    localparam int HALF_LEN  = DEFAULT_HALF_BLOCK_BYTES;

    // Percent of cycles in which each side idles while not in a calm stretch.
    localparam int IDLE_PCT = 28;

    // Cycles allowed after the last expected group before the block counts as
    // idle. Dropped bytes never enter the four-entry command queue.
    localparam int SETTLE_CYCLES = 10;

    // Cycles without any handshake or register write before the run gives up.
    localparam int QUIET_LIMIT = 2000;

    // Opcode parser state of the predictor.
    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_RATE_TWO,
        PARSE_RATE_ONE,
        PARSE_COUNT
    } parse_state_t;

    // One group of cells as it should leave the block.
    typedef struct {
        logic [7:0] cells;
        logic [3:0] count;
        logic       is_weak;
        logic       last;
    } cell_group_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] track_byte
    logic                  s_axis_tlast = 1'b0; // track_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;        // [7:0] cell_bits, [11:8] cell_count
    logic                  m_axis_tuser;        // weak_cells
    logic                  m_axis_tlast;        // run_last

    // Predictor state: a copy of the block's registers and its parser.
    int           track_pos = 0;
    parse_state_t parse_state = PARSE_IDLE;
    logic         rand_pending = 1'b0;
    logic         v3_mode = 1'b1;
    logic         side_one = 1'b0;

    // Cell groups that the block still owes, oldest first.
    cell_group_t expected_groups [$];

    // Run statistics.
    int  errors = 0;
    int  sent_bytes = 0;
    int  kept_bytes = 0;
    int  groups_seen = 0;
    int  weak_seen = 0;
    int  reg_writes = 0;
    int  quiet_cycles = 0;
    // While set, neither side idles.
    bit  calm = 1'b0;

    hfe_track_bitcell_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror image of a byte. The v3 opcodes are defined on the reversed byte,
    // so the raw value that carries an opcode is its mirror image as well.
    function automatic logic [7:0] flip_bits(input logic [7:0] value);
        logic [7:0] flipped;
        for (int i = 0; i < 8; i++)
        begin
            flipped[i] = value[7 - i];
        end
        return flipped;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void push_group(input logic [7:0] cells, input logic [3:0] count,
                                       input logic weak_flag);
        cell_group_t group;
        group.cells   = cells;
        group.count   = count;
        group.is_weak = weak_flag;
        group.last    = 1'b0;
        expected_groups.insert(expected_groups.size(), group);
    endfunction

    // True when the byte at the current track position belongs to the
    // selected disk side.
    function automatic bit on_selected_side();
        return side_one ? (track_pos >= HALF_LEN) : (track_pos < HALF_LEN);
    endfunction

    // Works out the cell groups caused by one accepted track byte, queues them
    // and advances the predictor. Returns whether the byte was on the selected
    // side.
    function automatic bit decode_track_byte(input logic [7:0] raw, input logic end_flag);
        logic [7:0] flipped;
        int         groups_before;
        int         left;
        int         chunk;
        bit         kept;
        kept          = on_selected_side();
        groups_before = expected_groups.size();
        flipped       = flip_bits(raw);
        if (kept)
        begin
            if (!v3_mode)
            begin
                // v1 ignores the parser entirely and leaves it as it stands.
                push_group(raw, 4'd8, 1'b0);
            end
            else
            begin
                case (parse_state)
                    PARSE_RATE_TWO: parse_state = PARSE_RATE_ONE;
                    PARSE_RATE_ONE: parse_state = PARSE_IDLE;
                    PARSE_COUNT:
                    begin
                        // The byte is a run length; zero yields nothing.
                        left = flipped;
                        while (left > 0)
                        begin
                            chunk = (left > 8) ? 8 : left;
                            push_group(8'h00, 4'(chunk), rand_pending);
                            left -= chunk;
                        end
                        parse_state  = PARSE_IDLE;
                        rand_pending = 1'b0;
                    end
                    default:
                    begin
                        if (flipped == OP_NOP || flipped == OP_INDEX)
                        begin
                            // Dropped without trace.
                        end
                        else if (flipped == OP_BITRATE)
                        begin
                            parse_state = PARSE_RATE_TWO;
                        end
                        else if (flipped == OP_SKIP || flipped == OP_RAND)
                        begin
                            parse_state  = PARSE_COUNT;
                            rand_pending = (flipped == OP_RAND);
                        end
                        else
                        begin
                            push_group(raw, 4'd8, 1'b0);
                        end
                    end
                endcase
            end
        end
        if (expected_groups.size() > groups_before)
            expected_groups[expected_groups.size() - 1].last = 1'b1;
        track_pos = (track_pos + 1) % BLOCK_LEN;
        // The end of a track clears position and parser, so an opcode whose
        // argument bytes were cut off never produces cells.
        if (end_flag)
        begin
            track_pos    = 0;
            parse_state  = PARSE_IDLE;
            rand_pending = 1'b0;
        end
        return kept;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at group %0d: %s is %0d, expected %0d",
                 groups_seen, what, got, want);
        errors++;
    endtask

    // Sends one item. Called at a rising edge; returns at the edge that
    // accepted the item, with tvalid still high so that back-to-back items
    // need no gap.
    task automatic send_byte(input logic [7:0] value, input logic end_flag);
        while (!calm && chance(IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= end_flag;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_bytes++;
        if (decode_track_byte(value, end_flag))
            kept_bytes++;
    endtask

    // Holds the input off until every expected group has come out, then waits
    // out the settle time so that stray groups can show.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] index, input logic value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_FORMAT_V3)
            v3_mode = value;
        else
            side_one = value;
        reg_writes++;
    endtask

    // Run lengths lean toward short runs, with zero and the longest run
    // mixed in.
    function automatic logic [7:0] pick_run_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 8'd0;
        if (pick < 20)
            return 8'd255;
        if (pick < 80)
            return 8'($urandom_range(1, 20));
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one well-formed v3 element (data, a plain opcode, or an opcode
    // with its argument bytes) or, now and then, a raw noise byte. Each byte
    // ends the track with the given percent chance, which also cuts opcodes.
    task automatic send_token(input int end_pct);
        logic [7:0] data_byte;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            send_byte(8'($urandom_range(0, 255)), chance(end_pct));
        end
        else if (pick < 55)
        begin
            // Plain data: any byte whose mirror image is no opcode.
            do
                data_byte = 8'($urandom_range(0, 255));
            while (flip_bits(data_byte) inside {OP_NOP, OP_INDEX, OP_BITRATE, OP_SKIP,
                                                OP_RAND});
            send_byte(data_byte, chance(end_pct));
        end
        else if (pick < 62)
        begin
            send_byte(flip_bits(chance(50) ? OP_NOP : OP_INDEX), chance(end_pct));
        end
        else if (pick < 70)
        begin
            send_byte(flip_bits(OP_BITRATE), chance(end_pct));
            send_byte(8'($urandom_range(0, 255)), chance(end_pct));
            send_byte(8'($urandom_range(0, 255)), chance(end_pct));
        end
        else
        begin
            send_byte(flip_bits((pick < 85) ? OP_SKIP : OP_RAND), chance(end_pct));
            send_byte(flip_bits(pick_run_length()), chance(end_pct));
        end
    endtask

    // Every opcode and the parser's corner cases in the reset setting:
    // v3 format, side 0.
    task automatic test_opcode_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(flip_bits(OP_NOP), 1'b0);
        send_byte(flip_bits(OP_INDEX), 1'b0);
        // The two bytes after a bitrate opcode vanish, even if they look like
        // opcodes themselves.
        send_byte(flip_bits(OP_BITRATE), 1'b0);
        send_byte(flip_bits(OP_NOP), 1'b0);
        send_byte(flip_bits(OP_SKIP), 1'b0);
        // Runs of one cell, of the longest length, of zero, of exactly one
        // chunk and of one chunk plus one cell.
        send_byte(flip_bits(OP_SKIP), 1'b0);
        send_byte(flip_bits(8'd1), 1'b0);
        send_byte(flip_bits(OP_RAND), 1'b0);
        send_byte(flip_bits(8'd255), 1'b0);
        send_byte(flip_bits(OP_SKIP), 1'b0);
        send_byte(flip_bits(8'd0), 1'b0);
        send_byte(flip_bits(OP_SKIP), 1'b0);
        send_byte(flip_bits(8'd8), 1'b0);
        send_byte(flip_bits(OP_RAND), 1'b0);
        send_byte(flip_bits(8'd9), 1'b0);
        // Values just above the opcode range are data.
        send_byte(flip_bits(OP_RAND + 8'd1), 1'b0);
        send_byte(flip_bits(8'hF7), 1'b0);
        // A skip cut off by the end of the track; the next byte is parsed
        // afresh.
        send_byte(flip_bits(OP_SKIP), 1'b1);
        send_byte(flip_bits(8'd1), 1'b0);
        // A bitrate cut off after one of its two bytes.
        send_byte(flip_bits(OP_BITRATE), 1'b0);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
    endtask

    // v1 unpacking, and parser state carried across format changes.
    task automatic test_format_switch();
        write_reg(REG_FORMAT_V3, 1'b0);
        send_byte(flip_bits(OP_SKIP), 1'b0);
        send_byte(flip_bits(OP_RAND), 1'b0);
        send_byte(flip_bits(OP_BITRATE), 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Leave a rand opcode waiting for its count, decode two bytes in v1,
        // then let v3 pick up the count.
        write_reg(REG_FORMAT_V3, 1'b1);
        send_byte(flip_bits(OP_RAND), 1'b0);
        write_reg(REG_FORMAT_V3, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(flip_bits(OP_NOP), 1'b0);
        write_reg(REG_FORMAT_V3, 1'b1);
        send_byte(flip_bits(8'd12), 1'b1);
    endtask

    // Side selection within one track: side 0 is decoded for the first part
    // of the block, then side 1 is selected, so the rest of the first half is
    // skipped and the second half is decoded, first in v3 and then in v1.
    task automatic test_side_switch();
        while (track_pos < 120)
            send_token(0);
        write_reg(REG_SIDE_SELECT, 1'b1);
        while (track_pos < HALF_LEN + 45)
            send_token(0);
        write_reg(REG_FORMAT_V3, 1'b0);
        while (track_pos < HALF_LEN + 60)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // One random phase in a given register setting. On side 1 the bytes of
    // side 0 are streamed first without counting toward the goal.
    task automatic run_stream_phase(input logic fmt, input logic side, input int kept_goal,
                                    input bit no_idle);
        int start;
        write_reg(REG_FORMAT_V3, fmt);
        write_reg(REG_SIDE_SELECT, side);
        calm  = no_idle;
        start = kept_bytes;
        while (kept_bytes - start < kept_goal)
        begin
            if (!on_selected_side())
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else
            begin
                // Now and then the sender holds off until the block is empty.
                if (chance(3))
                    wait_drained();
                send_token(side ? 0 : 4);
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_random_streams();
        run_stream_phase(1'b1, 1'b0, 30, 1'b0);
        run_stream_phase(1'b0, 1'b0, 10, 1'b0);
        run_stream_phase(1'b1, 1'b0, 25, 1'b1);
    endtask

    // The receiver stalls at random, except during a calm stretch.
    always @(posedge clk)
    begin
        m_axis_tready <= calm || !chance(IDLE_PCT);
    end

    // Compares each accepted group with the oldest expectation.
    always @(posedge clk)
    begin
        cell_group_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_groups.size() == 0)
            begin
                report_mismatch("unexpected group, cell_bits", m_axis_tdata[7:0], -1);
            end
            else
            begin
                want = expected_groups.pop_front();
                if (m_axis_tdata[7:0] !== want.cells)
                    report_mismatch("cell_bits", m_axis_tdata[7:0], want.cells);
                if (m_axis_tdata[11:8] !== want.count)
                    report_mismatch("cell_count", m_axis_tdata[11:8], want.count);
                if (m_axis_tuser !== want.is_weak)
                    report_mismatch("weak_cells", m_axis_tuser, want.is_weak);
                if (m_axis_tlast !== want.last)
                    report_mismatch("run_last", m_axis_tlast, want.last);
                if (want.is_weak)
                    weak_seen++;
            end
            groups_seen++;
        end
    end

    // Ends a hung run, in which no handshake or register write happens any more.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_opcode_directed();
        test_format_switch();
        test_side_switch();
        test_random_streams();

        // Let the last groups out and give stray ones a chance to show.
        wait_drained();
        if (expected_groups.size() != 0)
            report_mismatch("groups left pending", expected_groups.size(), 0);

        $display("Streamed %0d track bytes, %0d of them on the selected side, over %0d",
                 sent_bytes, kept_bytes, reg_writes);
        $display("register writes; checked %0d cell groups, %0d of them weak.",
                 groups_seen, weak_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/hfe_tbe_pkg.sv
sv/hfe_tbe_front.sv
sv/hfe_tbe_queue.sv
sv/hfe_tbe_back.sv
sv/hfe_track_bitcell_extractor.sv
tb/tb.sv
